FILE: rtl/core/circle_trixel_edge_intersect_unit_assert.svh
`ifndef CIRCLE_TRIXEL_EDGE_INTERSECT_UNIT_ASSERT_SVH
`define CIRCLE_TRIXEL_EDGE_INTERSECT_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CTIE_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define CTIE_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error(msg);

`endif

FILE: rtl/core/ctie_pkg.sv
package ctie_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int NSTG          = 8;
    localparam int NLANE         = 3;

    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_Z  = 3'd2;
    localparam logic [2:0] REG_PLANE_D   = 3'd3;
    localparam logic [2:0] REG_TOLERANCE = 3'd4;

    localparam logic signed [31:0] CENTER_X_RST = 32'sd0;
    localparam logic signed [31:0] CENTER_Y_RST = 32'sd0;
    localparam logic signed [31:0] CENTER_Z_RST = 32'sd1073741824;
    localparam logic signed [31:0] PLANE_D_RST  = 32'sd0;
    localparam logic [19:0]        TOL_RST      = 20'd1;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } vec_t;

    // Per-stage load enables shared by all lanes
    typedef struct packed {
        logic [NSTG-1:0] en;
    } ctie_ctl_t;

endpackage

FILE: rtl/core/ctie_lane.sv
module ctie_lane #(
    parameter int FRAC_BITS = ctie_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  ctie_pkg::ctie_ctl_t ctl,
    input  ctie_pkg::vec_t      p,
    input  ctie_pkg::vec_t      q,
    input  ctie_pkg::vec_t      c,
    input  logic signed [31:0]  dq,
    input  logic [19:0]         tol,
    output logic                hit
);
    import ctie_pkg::*;

    localparam int SW  = (2 * FRAC_BITS + 2 > 66) ? 2 * FRAC_BITS + 2 : 66;
    localparam int RSH = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int LSH = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
    localparam int TW  = (64 + FRAC_BITS > 84) ? 64 + FRAC_BITS : 84;
    localparam logic signed [SW-1:0] LIM = SW'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [33:0]   WONE = 34'sd1073741824;

    // Saturated dot product brought to Q.30
    function automatic logic signed [31:0] sat_dot(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic signed [63:0] e);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] t;
        s = SW'(a) + SW'(b) + SW'(e);
        if (s > LIM) s = LIM;
        if (s < -LIM) s = -LIM;
        t = (s <<< LSH) >>> RSH;
        return t[31:0];
    endfunction

    logic signed [63:0]  pr_reg [9];
    logic signed [31:0]  g1_reg, g2_reg, k_reg;
    logic signed [33:0]  d_reg, n_reg, gp_reg, gm_reg;
    logic signed [31:0]  g1b_reg, kb_reg, g2b_reg;
    logic signed [63:0]  pa_reg, pc_reg, pk_reg, g2s_reg;
    logic [51:0]         td3_reg, td4_reg, td5_reg;
    logic                dz3_reg, dz4_reg, dz5_reg, dz6_reg;
    logic signed [63:0]  a_reg, b_reg, c0_reg;
    logic signed [63:0]  bbhh_reg, achh_reg;
    logic signed [64:0]  bbhl_reg, achl_reg, aclh_reg;
    logic [63:0]         bbll_reg, acll_reg, mag_reg;
    logic signed [63:0]  an_reg, bn_reg, cn_reg;
    logic                az5_reg, az6_reg;
    logic signed [128:0] bb_reg, ac_reg;
    logic                tol_lt_reg, root_reg;
    logic                hit_reg;

    logic signed [31:0]  bh, ah, ch;
    logic signed [32:0]  bl, al, cl;
    logic signed [65:0]  q1, t2;
    logic signed [128:0] disc;

    assign bh = b_reg[63:32];
    assign ah = a_reg[63:32];
    assign ch = c0_reg[63:32];
    assign bl = {1'b0, b_reg[31:0]};
    assign al = {1'b0, a_reg[31:0]};
    assign cl = {1'b0, c0_reg[31:0]};
    assign q1 = 66'(an_reg) + 66'(bn_reg) + 66'(cn_reg);
    assign t2 = (66'(an_reg) <<< 1) + 66'(bn_reg);
    assign disc = bb_reg - (ac_reg <<< 2);

    // Dot product terms
    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            pr_reg[0] <= p.x * c.x;
            pr_reg[1] <= p.y * c.y;
            pr_reg[2] <= p.z * c.z;
            pr_reg[3] <= q.x * c.x;
            pr_reg[4] <= q.y * c.y;
            pr_reg[5] <= q.z * c.z;
            pr_reg[6] <= p.x * q.x;
            pr_reg[7] <= p.y * q.y;
            pr_reg[8] <= p.z * q.z;
        end
    end

    // Sum, saturate, rescale
    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            g1_reg <= sat_dot(pr_reg[0], pr_reg[1], pr_reg[2]);
            g2_reg <= sat_dot(pr_reg[3], pr_reg[4], pr_reg[5]);
            k_reg  <= sat_dot(pr_reg[6], pr_reg[7], pr_reg[8]);
        end
    end

    // Edge scale terms
    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            d_reg   <= WONE + 34'(k_reg);
            n_reg   <= WONE - 34'(k_reg);
            gp_reg  <= 34'(g1_reg) + 34'(dq);
            gm_reg  <= 34'(g1_reg) - 34'(dq);
            g1b_reg <= g1_reg;
            kb_reg  <= k_reg;
            g2b_reg <= g2_reg;
        end
    end

    // Coefficient products
    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            pa_reg  <= n_reg * gp_reg;
            pc_reg  <= d_reg * gm_reg;
            pk_reg  <= g1b_reg * kb_reg;
            g2s_reg <= 64'(g2b_reg) <<< 30;
            td3_reg <= 52'(tol) * 52'(d_reg[31:0]);
            dz3_reg <= (d_reg == 34'sd0);
        end
    end

    // Quadratic coefficients
    always_ff @(posedge aclk) begin
        if (ctl.en[4]) begin
            a_reg   <= -pa_reg;
            b_reg   <= (g2s_reg - pk_reg) <<< 1;
            c0_reg  <= pc_reg;
            td4_reg <= td3_reg;
            dz4_reg <= dz3_reg;
        end
    end

    // Partial products, magnitude, sign normalising
    always_ff @(posedge aclk) begin
        if (ctl.en[5]) begin
            bbhh_reg <= bh * bh;
            bbhl_reg <= bh * bl;
            bbll_reg <= b_reg[31:0] * b_reg[31:0];
            achh_reg <= ah * ch;
            achl_reg <= ah * cl;
            aclh_reg <= al * ch;
            acll_reg <= a_reg[31:0] * c0_reg[31:0];
            mag_reg  <= a_reg[63] ? 64'(-a_reg) : 64'(a_reg);
            an_reg   <= a_reg[63] ? -a_reg : a_reg;
            bn_reg   <= a_reg[63] ? -b_reg : b_reg;
            cn_reg   <= a_reg[63] ? -c0_reg : c0_reg;
            az5_reg  <= (a_reg == 64'sd0);
            td5_reg  <= td4_reg;
            dz5_reg  <= dz4_reg;
        end
    end

    // Sum partials, tolerance and root position tests
    always_ff @(posedge aclk) begin
        if (ctl.en[6]) begin
            bb_reg     <= (129'(bbhh_reg) <<< 64) + (129'(bbhl_reg) <<< 33)
                          + 129'(bbll_reg);
            ac_reg     <= (129'(achh_reg) <<< 64) + (129'(achl_reg) <<< 32)
                          + (129'(aclh_reg) <<< 32) + 129'(acll_reg);
            tol_lt_reg <= ((TW'(mag_reg) << FRAC_BITS) < (TW'(td5_reg) << 30));
            root_reg   <= ((cn_reg <= 64'sd0) && (q1 >= 66'sd0))
                          || ((cn_reg >= 64'sd0) && (q1 <= 66'sd0))
                          || ((cn_reg > 64'sd0) && (bn_reg < 64'sd0) && (t2 > 66'sd0));
            az6_reg    <= az5_reg;
            dz6_reg    <= dz5_reg;
        end
    end

    // Discriminant sign and final decision
    always_ff @(posedge aclk) begin
        if (ctl.en[7]) begin
            hit_reg <= !dz6_reg && !disc[128] && !az6_reg && !tol_lt_reg && root_reg;
        end
    end

    assign hit = hit_reg;

endmodule

FILE: rtl/core/ctie_merge.sv
module ctie_merge (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  logic [ctie_pkg::NLANE-1:0]      lane_hits,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata   // [0] hit, [3:1] edge_hits
);
    import ctie_pkg::*;

    logic             valid_reg;
    logic [NLANE-1:0] edges_reg;

    assign in_ready = !valid_reg || m_tready;

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Hold lane results for the beat
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            edges_reg <= lane_hits;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, edges_reg, |edges_reg};

endmodule

FILE: rtl/core/circle_trixel_edge_intersect_unit.sv
// Channel   | Dir | Beat contents
// s_ (in)   | in  | tdata: 9 x 32 bit vertex coordinates, one triangle
// m_ (out)  | out | tdata: hit, edge_hits
// cfg_      | in  | register index and write data, no read-back
//
// One triangle per cycle while the output is not stalled; each result passes
// through eight lane stages, the first loaded when its triangle is accepted,
// then the output register. One lane per triangle edge; all run in lockstep.
// Reset clears all stage valid bits and loads the register reset values.
// A stalled output only stops stages that are full: empty stages keep filling.
module circle_trixel_edge_intersect_unit #(
    parameter int FRAC_BITS = ctie_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, 32 bit each
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] hit, [3:1] edge_hits, [7:4] zero
    output logic [7:0]   m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wr_data
);
    import ctie_pkg::*;

    localparam int DW   = (FRAC_BITS + 2 > 34) ? FRAC_BITS + 2 : 34;
    localparam int DRSH = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
    localparam int DLSH = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
    localparam logic signed [DW-1:0] DONE = DW'(1) <<< FRAC_BITS;

    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg, plane_d_reg;
    logic [19:0]        tol_reg;
    logic [NSTG-1:0]    v_reg;
    logic [NSTG:0]      rdy;
    logic               merge_ready;
    ctie_ctl_t          ctl;
    vec_t               vtx [3];
    vec_t               ctr;
    logic signed [DW-1:0] dsat;
    logic signed [DW-1:0] dsh;
    logic signed [31:0] dq;
    logic [NLANE-1:0]   lane_hits;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            center_z_reg <= CENTER_Z_RST;
            plane_d_reg  <= PLANE_D_RST;
            tol_reg      <= TOL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_X:  center_x_reg <= cfg_wr_data;
                REG_CENTER_Y:  center_y_reg <= cfg_wr_data;
                REG_CENTER_Z:  center_z_reg <= cfg_wr_data;
                REG_PLANE_D:   plane_d_reg  <= cfg_wr_data;
                REG_TOLERANCE: tol_reg      <= cfg_wr_data[19:0];
                default: ;
            endcase
        end
    end

    // Plane distance saturated and brought to Q.30
    always_comb begin
        dsat = DW'(plane_d_reg);
        if (dsat > DONE) dsat = DONE;
        if (dsat < -DONE) dsat = -DONE;
        dsh = (dsat <<< DLSH) >>> DRSH;
        dq  = dsh[31:0];
    end

    // Unpack vertices
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vtx[i].x = s_tdata[96*i +: 32];
            vtx[i].y = s_tdata[96*i + 32 +: 32];
            vtx[i].z = s_tdata[96*i + 64 +: 32];
        end
        ctr.x = center_x_reg;
        ctr.y = center_y_reg;
        ctr.z = center_z_reg;
    end

    // Stage ready chain: a stage loads when empty or when its successor loads
    always_comb begin
        rdy[NSTG] = merge_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        ctl.en = rdy[NSTG-1:0];
    end

    assign s_tready = rdy[0];

    // Advance stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= (i == 0) ? s_tvalid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // One lane per edge: 0-1, 1-2, 2-0
    for (genvar e = 0; e < NLANE; e++) begin : g_lane
        ctie_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk (aclk),
            .ctl  (ctl),
            .p    (vtx[e]),
            .q    (vtx[(e + 1) % 3]),
            .c    (ctr),
            .dq   (dq),
            .tol  (tol_reg),
            .hit  (lane_hits[e])
        );
    end

    ctie_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_reg[NSTG-1]),
        .lane_hits (lane_hits),
        .in_ready  (merge_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`include "circle_trixel_edge_intersect_unit_assert.svh"

    `CTIE_ASSERT_NOW(a_hit_is_or, m_tvalid, m_tdata[0] == (|m_tdata[3:1]), "hit mismatch")
    `CTIE_ASSERT_NOW(a_empty_ready, !v_reg[0], s_tready, "empty first stage not ready")
    `CTIE_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v_reg[0], "accepted beat lost")
    `CTIE_ASSERT_NEXT(a_last_to_out, v_reg[NSTG-1] && merge_ready, m_tvalid, "result lost")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

import ctie_pkg::*;

// Works out the expected edge crossings for each triangle and keeps them in order
class crossing_scoreboard;
    typedef logic signed [127:0] wide_t;

    logic signed [31:0] ctr_x, ctr_y, ctr_z, plane_d;
    logic [19:0]        tol;
    logic [3:0]         pending_crossings[$];
    int                 errors;
    int                 results_seen;
    int                 hits_seen;

    function new();
        ctr_x   = CENTER_X_RST;
        ctr_y   = CENTER_Y_RST;
        ctr_z   = CENTER_Z_RST;
        plane_d = PLANE_D_RST;
        tol     = TOL_RST;
        errors  = 0;
        results_seen = 0;
        hits_seen    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_CENTER_X:  ctr_x = val;
            REG_CENTER_Y:  ctr_y = val;
            REG_CENTER_Z:  ctr_z = val;
            REG_PLANE_D:   plane_d = val;
            REG_TOLERANCE: tol = val[19:0];
            default: ;
        endcase
    endfunction

    function wide_t wx(logic signed [31:0] v);
        wide_t r;
        r = v;
        return r;
    endfunction

    // Exact dot product, clamped to [-1, 1] and dropped to 30 fraction bits
    function wide_t dot_q30(vec_t p, vec_t q);
        wide_t s, lim;
        lim = wide_t'(1) <<< 60;
        s = wx(p.x) * wx(q.x) + wx(p.y) * wx(q.y) + wx(p.z) * wx(q.z);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        return s >>> 30;
    endfunction

    function bit edge_crossed(vec_t p, vec_t q);
        vec_t  c;
        wide_t w, dq, g1, g2, k, d, n, a, b, c0, disc, mag, q1;
        int    s0, s1;
        c.x = ctr_x;
        c.y = ctr_y;
        c.z = ctr_z;
        w   = wide_t'(1) <<< 30;
        dq  = wx(plane_d);
        if (dq > w) dq = w;
        if (dq < -w) dq = -w;
        g1 = dot_q30(p, c);
        g2 = dot_q30(q, c);
        k  = dot_q30(p, q);
        d  = w + k;
        n  = w - k;
        // antipodal endpoints: no crossing
        if (d == 0) return 0;
        a    = -n * (g1 + dq);
        b    = 2 * (w * g2 - g1 * k);
        c0   = d * (g1 - dq);
        disc = b * b - 4 * a * c0;
        if (disc < 0 || a == 0) return 0;
        mag = (a < 0) ? -a : a;
        if (mag * w < wide_t'(tol) * d * w) return 0;
        if (a < 0) begin
            a  = -a;
            b  = -b;
            c0 = -c0;
        end
        q1 = a + b + c0;
        s0 = (c0 > 0) ? 1 : ((c0 < 0) ? -1 : 0);
        s1 = (q1 > 0) ? 1 : ((q1 < 0) ? -1 : 0);
        // a sign change or a touch at either end of the edge
        if ((s0 <= 0 && s1 >= 0) || (s0 >= 0 && s1 <= 0)) return 1;
        // both roots inside with the vertex of the parabola in range
        if (s0 > 0 && b < 0 && (2 * a + b) > 0) return 1;
        return 0;
    endfunction

    function void note_triangle(logic [287:0] beat);
        vec_t       v0, v1, v2;
        logic [2:0] edges;
        v0 = beat[95:0];
        v1 = beat[191:96];
        v2 = beat[287:192];
        edges[0] = edge_crossed(v0, v1);
        edges[1] = edge_crossed(v1, v2);
        edges[2] = edge_crossed(v2, v0);
        pending_crossings.insert(pending_crossings.size(), {edges, |edges});
    endfunction

    function void check_result(logic [7:0] beat);
        logic [3:0] exp_bits;
        if (pending_crossings.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, beat);
            errors++;
            return;
        end
        exp_bits = pending_crossings.pop_front();
        results_seen++;
        if (exp_bits[0]) hits_seen++;
        if (beat[0] !== exp_bits[0]) begin
            $display("%0t: hit mismatch, expected %b actual %b", $time, exp_bits[0], beat[0]);
            errors++;
        end
        if (beat[3:1] !== exp_bits[3:1]) begin
            $display("%0t: edge_hits mismatch, expected %b actual %b",
                     $time, exp_bits[3:1], beat[3:1]);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         ONE_Q30 = 1073741824;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [7:0]   m_tdata;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wr_data = '0;

    crossing_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  long_hold_req = 0;
    int  cycles = 0;
    int  triangles_sent = 0;
    real cx = 0.0, cy = 0.0, cz = 1.0, dd = 0.0;

    circle_trixel_edge_intersect_unit dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                long_hold_req = 0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // One register write; the write enable is dropped again before the task returns
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en   <= 1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // Offer one triangle, hold it until accepted, then idle while a random draw falls under send_idle_pct
    task automatic send_triangle(logic [287:0] beat);
        s_tvalid <= 1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        sb.note_triangle(beat);
        triangles_sent++;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_crossings.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic logic [31:0] to_q30(real r);
        return $rtoi(r * ONE_Q30);
    endfunction

    function automatic logic [95:0] unit_vec(real x, real y, real z);
        real m;
        m = $sqrt(x * x + y * y + z * z);
        if (m < 1.0e-6) return {to_q30(1.0), 32'd0, 32'd0};
        return {to_q30(z / m), to_q30(y / m), to_q30(x / m)};
    endfunction

    function automatic real urand_real();
        return $urandom_range(0, 2000000) / 1.0e6 - 1.0;
    endfunction

    // A triangle scattered around a random point of the constraint circle
    function automatic logic [287:0] near_circle_triangle();
        real rx, ry, rz, rc, ux, uy, uz, um, sr, px, py, pz, spread;
        logic [287:0] t;
        rx = urand_real();
        ry = urand_real();
        rz = urand_real();
        rc = rx * cx + ry * cy + rz * cz;
        ux = rx - rc * cx;
        uy = ry - rc * cy;
        uz = rz - rc * cz;
        um = $sqrt(ux * ux + uy * uy + uz * uz) + 1.0e-9;
        sr = (dd * dd < 1.0) ? $sqrt(1.0 - dd * dd) : 0.0;
        px = dd * cx + sr * ux / um;
        py = dd * cy + sr * uy / um;
        pz = dd * cz + sr * uz / um;
        spread = $urandom_range(1, 300) / 1000.0;
        for (int i = 0; i < 3; i++)
            t[i*96 +: 96] = unit_vec(px + spread * urand_real(), py + spread * urand_real(),
                                     pz + spread * urand_real());
        return t;
    endfunction

    task automatic random_triangles(int count);
        logic [287:0] t;
        int           sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                t = near_circle_triangle();
            end else if (sel < 90) begin
                for (int j = 0; j < 3; j++)
                    t[j*96 +: 96] = unit_vec(urand_real(), urand_real(), urand_real());
            end else begin
                for (int j = 0; j < 9; j++) t[j*32 +: 32] = $urandom();
            end
            send_triangle(t);
        end
    endtask

    task automatic set_constraint(real x, real y, real z, real d, logic [19:0] t);
        logic [95:0] c;
        c = unit_vec(x, y, z);
        cx = x; cy = y; cz = z; dd = d;
        write_reg(REG_CENTER_X, c[31:0]);
        write_reg(REG_CENTER_Y, c[63:32]);
        write_reg(REG_CENTER_Z, c[95:64]);
        write_reg(REG_PLANE_D, to_q30(d));
        write_reg(REG_TOLERANCE, {12'd0, t});
    endtask

    initial begin
        logic [95:0] px, nx, pz, nz, py;
        real         rx, ry, rz, m;
        px = unit_vec(1, 0, 0);
        nx = unit_vec(-1, 0, 0);
        py = unit_vec(0, 1, 0);
        pz = unit_vec(0, 0, 1);
        nz = unit_vec(0, 0, -1);

        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed triangles under the reset constraint (equator circle)
        send_triangle({pz, py, px});
        send_triangle({unit_vec(1, 0, -1), unit_vec(0, 1, 1), unit_vec(1, 1, 1)});
        send_triangle({unit_vec(0.1, 0, 1), unit_vec(0, 0.1, 1), pz});
        send_triangle({py, nz, pz});
        send_triangle({nx, px, py});
        send_triangle({px, px, px});
        send_triangle('0);
        send_triangle({9{32'h7fffffff}});
        send_triangle({9{32'h80000000}});
        send_triangle({9{32'h55555555}});
        send_triangle({9{32'haaaaaaaa}});
        send_triangle({unit_vec(0, 0, -1), unit_vec(1, 0, 0.001), unit_vec(1, 0, -0.001)});
        drain();
        write_reg(REG_UNUSED, 32'hffffffff);

        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 31 : ((phase < 4) ? 56 : 0);
            recv_idle_pct = (phase < 2) ? 56 : ((phase < 4) ? 31 : 0);
            case (phase)
                0: set_constraint(1, 0, 0, 1.0, 20'd0);
                1: set_constraint(0, 1, 0, -1.0, 20'hfffff);
                2: set_constraint(0, 0, 1, 0.5, 20'd0);
                3: begin
                    set_constraint(1, 1, 1, 0.0, 20'd1);
                    long_hold_req = 1;
                end
                4: begin
                    // raw extremes: out of range centre and plane distance
                    write_reg(REG_CENTER_X, 32'h80000000);
                    write_reg(REG_CENTER_Y, 32'h7fffffff);
                    write_reg(REG_CENTER_Z, 32'h00000001);
                    write_reg(REG_PLANE_D, 32'h7fffffff);
                    write_reg(REG_TOLERANCE, $urandom());
                end
                default: begin
                    rx = urand_real(); ry = urand_real(); rz = urand_real();
                    m = $sqrt(rx * rx + ry * ry + rz * rz) + 1.0e-9;
                    set_constraint(rx / m, ry / m, rz / m, urand_real(),
                                   $urandom_range(0, 4096));
                end
            endcase
            random_triangles(165);
            drain();
        end

        $display("%0d triangles sent, %0d results checked, %0d with a crossing",
                 triangles_sent, sb.results_seen, sb.hits_seen);
        $display("six constraint settings incl. extremes, stalls on both sides, one long hold");
        if (sb.errors == 0 && sb.pending_crossings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: circle_trixel_edge_intersect_unit.f
+incdir+rtl/core
rtl/core/ctie_pkg.sv
rtl/core/ctie_lane.sv
rtl/core/ctie_merge.sv
rtl/core/circle_trixel_edge_intersect_unit.sv
tb/tb.sv
